/* hdl/grid_slot_table_first_free_macros.svh */
// Assertion macros shared by the grid slot table RTL.
`ifndef GRID_SLOT_TABLE_FIRST_FREE_MACROS_SVH
`define GRID_SLOT_TABLE_FIRST_FREE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define GSTFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define GSTFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gstff_pkg.sv */
// Shared types and constants of the grid slot table.
package gstff_pkg;

    // Request commands carried on the slave tuser.
    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_PLACE  = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic CFG_ROWS_IN_USE = 1'b0;
    localparam logic CFG_COLS_IN_USE = 1'b1;

    // Field widths fixed by the stream format.
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 3;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 7;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 64;

    // Reset value of both grid dimension registers.
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

    // Grid coordinates of the encoder; four bits cover up to sixteen rows or columns.
    localparam int GRID_IDX_W = 4;

    // First free slot found by the priority encoder.
    typedef struct packed {
        logic                  found;
        logic [GRID_IDX_W-1:0] row;
        logic [GRID_IDX_W-1:0] col;
    } t_ff_res;

endpackage

/* hdl/grid_slot_table_first_free.sv */
// An accepted request passes through the input register and then the result register.
// Throughput: one request per cycle while the result stream does not stall; the occupancy bitmap,
// the first-free encoder and the payload RAM port all resolve a request as it leaves the input register.
// Reset clears the occupancy bitmap, the occupied count and both stage valids, and sets
// both grid dimensions to eight. The payload RAM is not cleared; only data of occupied slots is returned.
module grid_slot_table_first_free #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLS    = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [gstff_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Request stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata from bit 0: row[3:0], col_index[6:4], value[38:7], zero pad[39].
    input  logic [gstff_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [gstff_pkg::CMD_W-1:0]      i_s_axis_tuser,
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata from bit 0: read_value[31:0], slot_was_occupied[32], address_error[33],
    // placed[34], placed_row[38:35], placed_col[41:39], occupied_count[48:42],
    // empty_count[55:49], is_full[56], is_empty[57], zero pad[63:58].
    output logic [gstff_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    import gstff_pkg::*;

    `include "grid_slot_table_first_free_macros.svh"

    localparam int SLOTS = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);
    localparam int SW    = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_rows;
    logic [CFG_DATA_W-1:0] r_cols;

    // Input register.
    logic             r_in_valid;
    t_cmd             r_cmd;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [VAL_W-1:0] r_val;

    // Table state.
    logic [SLOTS-1:0] r_occ;
    logic [SLOTS-1:0] n_occ;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register.
    logic                 r_out_valid;
    logic                 r_was;
    logic                 r_err;
    logic                 r_placed;
    logic [ROW_W-1:0]     r_prow;
    logic [COL_W-1:0]     r_pcol;
    logic [CNT_OUT_W-1:0] r_occ_cnt;
    logic [CNT_OUT_W-1:0] r_empty_cnt;
    logic                 r_full;
    logic                 r_empty;

    logic s_acc;
    logic m_acc;
    logic adv;

    logic [NR_W-1:0]  nrows;
    logic [NC_W-1:0]  ncols;
    logic [CNT_W-1:0] grid_size;
    logic [CNT_W-1:0] empty_cnt;
    logic             is_place;
    logic             addr_err;
    logic             was;
    logic [IDX_W-1:0] rw_addr;
    logic [IDX_W-1:0] place_addr;
    logic [IDX_W-1:0] op_addr;
    logic             do_set;
    logic             do_clr;
    logic             ram_we;
    logic [SW-1:0]    ram_rdata;
    t_ff_res          ff;

    // Handshakes: the input register advances whenever the result register is free.
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc           = r_out_valid && i_m_axis_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_RESET;
            r_cols <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_IN_USE: r_rows <= i_cfg_data;
                CFG_COLS_IN_USE: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd <= t_cmd'(i_s_axis_tuser);
            r_row <= i_s_axis_tdata[ROW_W-1:0];
            r_col <= i_s_axis_tdata[ROW_W +: COL_W];
            r_val <= i_s_axis_tdata[ROW_W+COL_W +: VAL_W];
        end
    end

    // Grid dimensions saturated into their legal ranges.
    always_comb begin
        if (r_rows == '0) begin
            nrows = NR_W'(1);
        end else if (r_rows > MAX_ROWS) begin
            nrows = NR_W'(MAX_ROWS);
        end else begin
            nrows = NR_W'(r_rows);
        end
        if (r_cols == '0) begin
            ncols = NC_W'(1);
        end else if (r_cols > MAX_COLS) begin
            ncols = NC_W'(MAX_COLS);
        end else begin
            ncols = NC_W'(r_cols);
        end
    end

    assign grid_size = CNT_W'(nrows) * CNT_W'(ncols);

    gstff_first_free #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_first_free (
        .i_occ   (r_occ),
        .i_nrows (nrows),
        .i_ncols (ncols),
        .o_res   (ff)
    );

    // Address decode and occupancy lookup of the addressed slot.
    assign is_place   = (r_cmd == CMD_PLACE);
    assign addr_err   = !is_place && ((r_row == '0) || (r_row > nrows) || (r_col >= ncols));
    assign rw_addr    = IDX_W'((32'(r_row) - 32'd1) * 32'(MAX_COLS) + 32'(r_col));
    assign place_addr = IDX_W'(32'(ff.row) * 32'(MAX_COLS) + 32'(ff.col));
    assign op_addr    = is_place ? place_addr : rw_addr;
    assign was        = !is_place && !addr_err && r_occ[rw_addr];

    // Bitmap and count updates.
    assign do_set = (is_place && ff.found) || ((r_cmd == CMD_WRITE) && !addr_err && !was);
    assign do_clr = (r_cmd == CMD_DELETE) && was;
    assign ram_we = adv && ((is_place && ff.found) || ((r_cmd == CMD_WRITE) && !addr_err));

    always_comb begin
        n_occ   = r_occ;
        n_count = r_count;
        if (do_set) begin
            n_occ[op_addr] = 1'b1;
            n_count        = r_count + CNT_W'(1);
        end else if (do_clr) begin
            n_occ[op_addr] = 1'b0;
            n_count        = r_count - CNT_W'(1);
        end
    end

    // Free slots saturate at zero when the grid shrinks below the occupancy.
    assign empty_cnt = (n_count >= grid_size) ? '0 : (grid_size - n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_count <= '0;
        end else if (adv) begin
            r_occ   <= n_occ;
            r_count <= n_count;
        end
    end

    // Payload store; its read data lines up with the result register.
    gstff_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (op_addr),
        .i_wdata (r_val[SW-1:0]),
        .i_re    (adv),
        .i_raddr (op_addr),
        .o_rdata (ram_rdata)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_was       <= was;
            r_err       <= addr_err;
            r_placed    <= is_place && ff.found;
            r_prow      <= (is_place && ff.found) ? ROW_W'(ff.row + GRID_IDX_W'(1)) : '0;
            r_pcol      <= (is_place && ff.found) ? COL_W'(ff.col) : '0;
            r_occ_cnt   <= CNT_OUT_W'(n_count);
            r_empty_cnt <= CNT_OUT_W'(empty_cnt);
            r_full      <= (empty_cnt == '0);
            r_empty     <= (n_count == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_empty, r_full, r_empty_cnt, r_occ_cnt, r_pcol, r_prow,
                              r_placed, r_err, r_was,
                              (r_was ? VAL_W'(ram_rdata) : VAL_W'(0))};

    // Checks on the table bookkeeping.
    `GSTFF_ASSERT_NOW(a_count_matches_map, 1'b1, r_count == CNT_W'($countones(r_occ)), "occupied count differs from bitmap")
    `GSTFF_ASSERT_NOW(a_err_is_quiet, r_out_valid && r_err, !r_was && !r_placed, "address error result reports a slot")
    `GSTFF_ASSERT_NOW(a_place_is_clean, r_out_valid && r_placed, !r_was && !r_err, "placement result reports a prior occupant")
    `GSTFF_ASSERT_NEXT(a_write_sets_bit, adv && (r_cmd == CMD_WRITE) && !addr_err, r_occ[$past(op_addr)], "valid write left slot empty")

endmodule

/* hdl/gstff_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gstff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read at the written address returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/gstff_first_free.sv */
// Row-major priority encoder that finds the first free slot of the configured grid.
module gstff_first_free #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic [MAX_ROWS*MAX_COLS-1:0] i_occ,
    input  logic [$clog2(MAX_ROWS+1)-1:0] i_nrows,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_ncols,
    output gstff_pkg::t_ff_res           o_res
);

    import gstff_pkg::*;

    logic [MAX_ROWS-1:0]   row_free;
    logic [GRID_IDX_W-1:0] row_col [MAX_ROWS];

    // Per row, the lowest free column inside the configured grid; then the lowest such row.
    always_comb begin
        row_free = '0;
        o_res    = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            row_col[r] = '0;
            for (int c = MAX_COLS - 1; c >= 0; c--) begin
                if (!i_occ[r*MAX_COLS + c] && (r < i_nrows) && (c < i_ncols)) begin
                    row_free[r] = 1'b1;
                    row_col[r]  = GRID_IDX_W'(c);
                end
            end
        end
        for (int r = MAX_ROWS - 1; r >= 0; r--) begin
            if (row_free[r]) begin
                o_res.found = 1'b1;
                o_res.row   = GRID_IDX_W'(r);
                o_res.col   = row_col[r];
            end
        end
    end

endmodule
